/* hdl/bvm_pkg.sv */
// Package for the battery voltage monitor: widths, register map, reset values,
// power level codes and the configuration struct. No dependencies.
`timescale 1ns / 1ps

package bvm_pkg;

  localparam int ADC_W   = 12;
  localparam int COEF_W  = 16;
  localparam int MV_W    = 15;
  localparam int LEVEL_W = 2;
  localparam int FV_W    = 31;           // Q15.16 filter value
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = FV_W + COEF_W;  // shared multiplier result
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  // register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_SCALE      = 3'd0;
  localparam logic [IDX_W-1:0] REG_ALPHA_FAST = 3'd1;
  localparam logic [IDX_W-1:0] REG_ALPHA_SLOW = 3'd2;
  localparam logic [IDX_W-1:0] REG_LOWEST     = 3'd3;
  localparam logic [IDX_W-1:0] REG_RETURN     = 3'd4;
  localparam logic [IDX_W-1:0] REG_WARN       = 3'd5;

  localparam logic [COEF_W-1:0] SCALE_RST      = 16'd36312;
  localparam logic [COEF_W-1:0] ALPHA_FAST_RST = 16'd2048;
  localparam logic [COEF_W-1:0] ALPHA_SLOW_RST = 16'd21;
  localparam logic [MV_W-1:0]   LOWEST_RST     = 15'd10000;
  localparam logic [MV_W-1:0]   RETURN_RST     = 15'd10500;
  localparam logic [MV_W-1:0]   WARN_RST       = 15'd11000;

  localparam logic [MV_W-1:0]   MV_MAX         = 15'h7FFF;
  localparam logic [FV_W-1:0]   FV_RST         = {15'd30000, 16'd0};
  localparam logic [FV_W-1:0]   SETTLE_MIN     = {15'd2000, 16'd0};
  localparam logic [FV_W-1:0]   SETTLE_WINDOW  = {15'd200, 16'd0};

  localparam logic [LEVEL_W-1:0] LVL_HIGH   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_WARN   = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_RETURN = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_LOWEST = 2'd3;

  typedef struct packed {
    logic [COEF_W-1:0] scale_q12;
    logic [COEF_W-1:0] alpha_fast;
    logic [COEF_W-1:0] alpha_slow;
    logic [MV_W-1:0]   lowest_mv;
    logic [MV_W-1:0]   return_mv;
    logic [MV_W-1:0]   warn_mv;
  } bvm_cfg_t;

endpackage

/* hdl/bvm_if.sv */
// Stream interfaces for the monitor: raw samples in, power levels out.
// Depends on bvm_pkg for field widths.
`timescale 1ns / 1ps

interface bvm_sample_if import bvm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bvm_level_if import bvm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] power_level;
  logic [MV_W-1:0]    filtered_mv;
  logic               settled;

  modport source (output valid, output power_level, output filtered_mv, output settled,
                  input ready);
  modport sink   (input valid, input power_level, input filtered_mv, input settled,
                  output ready);
endinterface

/* hdl/bvm_regs.sv */
// APB register file holding the gain, filter coefficients and thresholds.
// Depends on bvm_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps

module bvm_regs import bvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output bvm_cfg_t          cfg
);

  logic [IDX_W-1:0] idx;
  logic             wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_q12  <= SCALE_RST;
      cfg.alpha_fast <= ALPHA_FAST_RST;
      cfg.alpha_slow <= ALPHA_SLOW_RST;
      cfg.lowest_mv  <= LOWEST_RST;
      cfg.return_mv  <= RETURN_RST;
      cfg.warn_mv    <= WARN_RST;
    end else if (wr) begin
      case (idx)
        REG_SCALE:      cfg.scale_q12  <= pwdata[COEF_W-1:0];
        REG_ALPHA_FAST: cfg.alpha_fast <= pwdata[COEF_W-1:0];
        REG_ALPHA_SLOW: cfg.alpha_slow <= pwdata[COEF_W-1:0];
        REG_LOWEST:     cfg.lowest_mv  <= pwdata[MV_W-1:0];
        REG_RETURN:     cfg.return_mv  <= pwdata[MV_W-1:0];
        REG_WARN:       cfg.warn_mv    <= pwdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SCALE:      prdata = {{(DATA_W-COEF_W){1'b0}}, cfg.scale_q12};
      REG_ALPHA_FAST: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg.alpha_fast};
      REG_ALPHA_SLOW: prdata = {{(DATA_W-COEF_W){1'b0}}, cfg.alpha_slow};
      REG_LOWEST:     prdata = {{(DATA_W-MV_W){1'b0}}, cfg.lowest_mv};
      REG_RETURN:     prdata = {{(DATA_W-MV_W){1'b0}}, cfg.return_mv};
      REG_WARN:       prdata = {{(DATA_W-MV_W){1'b0}}, cfg.warn_mv};
      default:        prdata = '0;
    endcase
  end

endmodule

/* hdl/bvm_core.sv */
// Sequenced datapath: scale, settle check, filter step and classification,
// all around one shared 31x16 multiplier. Depends on bvm_pkg.
`timescale 1ns / 1ps

module bvm_core import bvm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  bvm_cfg_t           cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ADC_W-1:0]   adc_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] power_level,
  output logic [MV_W-1:0]    filtered_mv,
  output logic               settled
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCALE = 6'b000010,
    S_DIFF  = 6'b000100,
    S_STEP  = 6'b001000,
    S_UPD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t            state;
  logic [ADC_W-1:0]  adc;
  logic [FV_W-1:0]   fv;
  logic              settled_flag;
  logic [FV_W-1:0]   mag;
  logic              below;
  logic [COEF_W-1:0] alpha;
  logic [PROD_W-1:0] prod;

  logic [FV_W-1:0]   mul_a;
  logic [COEF_W-1:0] mul_b;
  logic [MV_W:0]     mv_raw;
  logic [MV_W-1:0]   mv;
  logic [FV_W-1:0]   target;
  logic              tgt_below;
  logic [FV_W-1:0]   mag_calc;
  logic [FV_W-1:0]   stepv;
  logic [MV_W-1:0]   fmv;
  logic [LEVEL_W-1:0] lvl;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // shared multiplier operands: gain product first, filter step second
  always_comb begin
    if (state == S_SCALE) begin
      mul_a = {{(FV_W-ADC_W){1'b0}}, adc};
      mul_b = cfg.scale_q12;
    end else begin
      mul_a = mag;
      mul_b = alpha;
    end
  end

  // gain product fits in 28 bits; saturate the integer millivolts
  assign mv_raw    = prod[ADC_W+MV_W:ADC_W];
  assign mv        = mv_raw[MV_W] ? MV_MAX : mv_raw[MV_W-1:0];
  assign target    = {mv, {FRAC_W{1'b0}}};
  assign tgt_below = target < fv;
  assign mag_calc  = tgt_below ? (fv - target) : (target - fv);
  assign stepv     = prod[FRAC_W+FV_W-1:FRAC_W];

  assign fmv = fv[FV_W-1:FRAC_W];

  always_comb begin
    if (fmv < cfg.lowest_mv)      lvl = LVL_LOWEST;
    else if (fmv < cfg.return_mv) lvl = LVL_RETURN;
    else if (fmv < cfg.warn_mv)   lvl = LVL_WARN;
    else                          lvl = LVL_HIGH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fv           <= FV_RST;
      settled_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            adc   <= adc_sample;
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          prod  <= mul_a * mul_b;
          state <= S_DIFF;
        end
        S_DIFF: begin
          // coefficient follows the flag as it was before this item
          alpha <= settled_flag ? cfg.alpha_slow : cfg.alpha_fast;
          mag   <= mag_calc;
          below <= tgt_below;
          if (!settled_flag && (fv > SETTLE_MIN) && (mag_calc < SETTLE_WINDOW))
            settled_flag <= 1'b1;
          state <= S_STEP;
        end
        S_STEP: begin
          prod  <= mul_a * mul_b;
          state <= S_UPD;
        end
        S_UPD: begin
          // step is truncated, so the value never passes the target
          fv    <= below ? (fv - stepv) : (fv + stepv);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            power_level <= lvl;
            filtered_mv <= fmv;
            settled     <= settled_flag;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/battery_voltage_monitor.sv */
// Top level of the battery voltage monitor: APB registers plus the filter core.
// Depends on bvm_pkg, bvm_if, bvm_regs and bvm_core.
//
//  channel  | kind            | payload
//  ---------+-----------------+----------------------------------------
//  sample   | stream, sink    | adc_sample[11:0]
//  level    | stream, source  | power_level[1:0], filtered_mv[14:0], settled
//  apb      | register port   | six registers at byte address 4*index
//
// One item goes through the scale, diff, step, update and output states before the
// next is accepted: the shared multiplier is used twice (gain, then filter step)
// with a register after each. The result is held in an output register; the next
// item is accepted while it waits. A stalled result holds the core in its last
// step until the register frees. Reset (rst, synchronous) restores the
// register defaults, a 30000 mV filter value and a cleared settled flag.
`timescale 1ns / 1ps

module battery_voltage_monitor import bvm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  bvm_sample_if.sink        sample,
  bvm_level_if.source       level,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  bvm_cfg_t cfg;

  bvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bvm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .adc_sample  (sample.adc_sample),
    .out_valid   (level.valid),
    .out_ready   (level.ready),
    .power_level (level.power_level),
    .filtered_mv (level.filtered_mv),
    .settled     (level.settled)
  );

endmodule

/* hdl/bvm_checker.sv */
// Port-level checks for the battery voltage monitor, bound to the top level.
// Depends on bvm_pkg for field widths.
`timescale 1ns / 1ps

module bvm_checker import bvm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LEVEL_W-1:0] power_level,
  input logic [MV_W-1:0]    filtered_mv,
  input logic               settled
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] inflight;
  logic       seen_settled;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight     <= 2'd0;
      seen_settled <= 1'b0;
    end else begin
      inflight <= inflight + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc && settled) seen_settled <= 1'b1;
    end
  end

  // one item at a time in the core
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input accepted while core still busy");

  // at most one in the core and one waiting at the output
  a_inflight: assert property (@(posedge clk) disable iff (rst)
    inflight != 2'd3)
    else $error("more items in flight than storage allows");

  // settling is permanent until reset
  a_settled_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_acc && seen_settled) |-> settled)
    else $error("settled flag dropped after being reported");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(power_level) && $stable(filtered_mv) && $stable(settled)))
    else $error("stalled result changed");

endmodule

bind battery_voltage_monitor bvm_checker u_bvm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (level.valid),
  .out_ready   (level.ready),
  .power_level (level.power_level),
  .filtered_mv (level.filtered_mv),
  .settled     (level.settled)
);

/* verif/battery_voltage_monitor_test.sv */
// Self-checking bench for battery_voltage_monitor: drives ADC samples and APB register
// writes, predicts each power level item in a bit-accurate filter model and compares.
// Depends on bvm_pkg, bvm_if and the monitor RTL.
`timescale 1ns / 1ps

module battery_voltage_monitor_test;
  import bvm_pkg::*;

  localparam int unsigned RAND_ITEMS    = 1950;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned TAIL_ITEMS    = 150;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned LONG_STALL_AT = 300;
  localparam int unsigned LONG_STALL    = 250;
  localparam int unsigned PAUSE_AT      = 1000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam int unsigned DIR_ROWS      = 49;

  // indexes past the register map; writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [LEVEL_W-1:0] power_level;
    logic [MV_W-1:0]    filtered_mv;
    logic               settled;
  } level_item_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [IDX_W-1:0]   idx;
    logic [DATA_W-1:0]  value;   // register data, or the ADC sample
    bit                 typed;
    level_item_t        want;
  } dir_row_t;

  localparam level_item_t NO_LEVEL      = '0;
  localparam level_item_t HOLD_AT_START = '{LVL_HIGH, 15'd30000, 1'b0};

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bvm_sample_if sample_ch ();
  bvm_level_if  level_ch ();

  battery_voltage_monitor dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .level   (level_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // filter model state and register copy
  bvm_cfg_t          reg_cfg;
  logic [FV_W-1:0]   fv_q16;
  logic              settled_q;

  level_item_t       pending_levels [$];
  int unsigned       mismatches   = 0;
  int unsigned       results_seen = 0;
  int unsigned       samples_sent = 0;
  int unsigned       rand_sent    = 0;
  int unsigned       reg_writes   = 0;
  int unsigned       cycles       = 0;
  bit                stall_req    = 1'b0;
  logic              tail_part;

  assign tail_part = (rand_sent >= RAND_ITEMS - TAIL_ITEMS);

  // Start at 30000 mV: alpha zero holds, exact window edge, exact 2000 mV edge,
  // scale and threshold extremes, dropped writes, then settle and stay settled.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_WRITE,  REG_ALPHA_FAST, 32'd0,     1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b1, HOLD_AT_START},
    '{ROW_SAMPLE, '0,             32'd4095,  1'b1, HOLD_AT_START},
    '{ROW_WRITE,  REG_SCALE,      32'd40960, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd2980,  1'b1, HOLD_AT_START},
    '{ROW_SAMPLE, '0,             32'd3020,  1'b1, HOLD_AT_START},
    '{ROW_WRITE,  REG_ALPHA_FAST, 32'd32768, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd200,   1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_ALPHA_FAST, 32'd57344, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd200,   1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_ALPHA_FAST, 32'd65535, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_SCALE,      32'd65535, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd4095,  1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd1,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_SCALE,      32'd0,     1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd4095,  1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_LOWEST,     32'd20000, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_RETURN,     32'd10000, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_WARN,       32'd5000,  1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_SCALE,      32'd40960, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_ALPHA_FAST, 32'd32768, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd3000,  1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd3000,  1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_LOWEST,     32'd0,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_RETURN,     32'd0,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_WARN,       32'd32767, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd4095,  1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_SPARE_LO,   32'hFFFF,  1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_SPARE_HI,   32'd0,     1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_LOWEST,     32'd32767, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_RETURN,     32'd32767, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_WARN,       32'd32767, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_LOWEST,     32'd10000, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_RETURN,     32'd10500, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_WARN,       32'd11000, 1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_ALPHA_FAST, 32'd65535, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd1000,  1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd1000,  1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_ALPHA_SLOW, 32'd0,     1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_WRITE,  REG_ALPHA_SLOW, 32'd65535, 1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd0,     1'b0, NO_LEVEL},
    '{ROW_SAMPLE, '0,             32'd4095,  1'b0, NO_LEVEL}
  };

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d items still expected",
               $time, cycles, pending_levels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Advance the filter model by one sample and classify the new value.
  function automatic level_item_t filter_step(input logic [ADC_W-1:0] adc);
    logic [ADC_W+COEF_W-1:0] gain_prod;
    logic [COEF_W-1:0]       mv_raw;
    logic [MV_W-1:0]         mv;
    logic [FV_W-1:0]         target;
    logic [FV_W-1:0]         gap;
    logic [PROD_W-1:0]       step_prod;
    logic [COEF_W-1:0]       alpha;
    logic                    below;
    level_item_t             r;
    gain_prod = adc * reg_cfg.scale_q12;
    mv_raw    = gain_prod[ADC_W+COEF_W-1:ADC_W];
    mv        = mv_raw[COEF_W-1] ? MV_MAX : mv_raw[MV_W-1:0];
    alpha     = settled_q ? reg_cfg.alpha_slow : reg_cfg.alpha_fast;
    target    = {mv, {FRAC_W{1'b0}}};
    below     = target < fv_q16;
    gap       = below ? fv_q16 - target : target - fv_q16;
    // settle test uses the value before this update
    if (!settled_q && fv_q16 > SETTLE_MIN && gap < SETTLE_WINDOW)
      settled_q = 1'b1;
    step_prod = gap * alpha;
    if (below)
      fv_q16 = fv_q16 - step_prod[FRAC_W +: FV_W];
    else
      fv_q16 = fv_q16 + step_prod[FRAC_W +: FV_W];
    r.filtered_mv = fv_q16[FV_W-1:FRAC_W];
    if (r.filtered_mv < reg_cfg.lowest_mv)
      r.power_level = LVL_LOWEST;
    else if (r.filtered_mv < reg_cfg.return_mv)
      r.power_level = LVL_RETURN;
    else if (r.filtered_mv < reg_cfg.warn_mv)
      r.power_level = LVL_WARN;
    else
      r.power_level = LVL_HIGH;
    r.settled = settled_q;
    return r;
  endfunction

  function automatic void store_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_SCALE:      reg_cfg.scale_q12  = value[COEF_W-1:0];
      REG_ALPHA_FAST: reg_cfg.alpha_fast = value[COEF_W-1:0];
      REG_ALPHA_SLOW: reg_cfg.alpha_slow = value[COEF_W-1:0];
      REG_LOWEST:     reg_cfg.lowest_mv  = value[MV_W-1:0];
      REG_RETURN:     reg_cfg.return_mv  = value[MV_W-1:0];
      REG_WARN:       reg_cfg.warn_mv    = value[MV_W-1:0];
      default: ;
    endcase
  endfunction

  // Uniform samples most often, some small moves, rail values and aims at a threshold.
  function automatic logic [ADC_W-1:0] pick_adc(input logic [ADC_W-1:0] last);
    int unsigned mode;
    int unsigned thr;
    int          aim;
    int          v;
    mode = $urandom_range(0, 9);
    if (mode <= 3) begin
      v = $urandom_range(0, 4095);
    end else if (mode <= 6) begin
      v = int'(last) + int'($urandom_range(0, 30)) - 15;
    end else if (mode == 7) begin
      v = ($urandom_range(0, 1) == 1) ? 4095 : 0;
    end else begin
      case ($urandom_range(0, 2))
        0:       thr = reg_cfg.lowest_mv;
        1:       thr = reg_cfg.return_mv;
        default: thr = reg_cfg.warn_mv;
      endcase
      aim = int'(thr) + int'($urandom_range(0, 400)) - 200;
      if (aim < 0)
        aim = 0;
      if (reg_cfg.scale_q12 == 0)
        v = $urandom_range(0, 4095);
      else
        v = (aim * 4096) / int'(reg_cfg.scale_q12);
    end
    if (v < 0)
      v = 0;
    if (v > 4095)
      v = 4095;
    return ADC_W'(v);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_sample(input logic [ADC_W-1:0] adc, input bit typed,
                             input level_item_t want);
    level_item_t predicted;
    sample_ch.valid      <= 1'b1;
    sample_ch.adc_sample <= adc;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = filter_step(adc);
    pending_levels.push_back(typed ? want : predicted);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic source_gap();
    bit quiet;
    quiet = ((samples_sent / 100) % 4 == 3);
    if (!tail_part && !quiet && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Drop valid and hold until every expected item is out, then let the core go idle.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_levels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    store_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure_phase(input int unsigned p);
    logic [COEF_W-1:0] scale;
    logic [COEF_W-1:0] slow;
    logic [MV_W-1:0]   t0;
    logic [MV_W-1:0]   t1;
    logic [MV_W-1:0]   t2;
    logic [MV_W-1:0]   tmp;
    scale = COEF_W'($urandom_range(16000, 65535));
    slow  = COEF_W'($urandom_range(0, 65535));
    t0    = MV_W'($urandom_range(0, 32767));
    t1    = MV_W'($urandom_range(0, 32767));
    t2    = MV_W'($urandom_range(0, 32767));
    // keep thresholds ordered except in the phase that scrambles them
    if (p != 6) begin
      if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
      if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
      if (t0 > t1) begin tmp = t0; t0 = t1; t1 = tmp; end
    end
    case (p)
      0: begin
        scale = SCALE_RST;
        slow  = ALPHA_SLOW_RST;
        t0    = LOWEST_RST;
        t1    = RETURN_RST;
        t2    = WARN_RST;
      end
      1: scale = '0;
      2: begin
        scale = '1;
        slow  = '1;
      end
      3: slow = '0;
      4: begin
        t0 = '0;
        t1 = '0;
        t2 = '0;
      end
      5: begin
        slow = COEF_W'($urandom_range(1, 64));
        t0   = MV_MAX;
        t1   = MV_MAX;
        t2   = MV_MAX;
      end
      default: ;
    endcase
    // junk in the upper bits must be masked off
    write_reg(REG_SCALE,      {16'($urandom), scale});
    write_reg(REG_ALPHA_FAST, {16'($urandom), 16'($urandom)});
    write_reg(REG_ALPHA_SLOW, {16'($urandom), slow});
    write_reg(REG_LOWEST,     {17'($urandom), t0});
    write_reg(REG_RETURN,     {17'($urandom), t1});
    write_reg(REG_WARN,       {17'($urandom), t2});
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    level_item_t want;
    if (!rst && level_ch.valid && level_ch.ready) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: item with nothing expected, expected none actual %0d/%0d/%0d", $time,
                   level_ch.power_level, level_ch.filtered_mv, level_ch.settled);
      end else begin
        want = pending_levels.pop_front();
        check_field("power_level", want.power_level, level_ch.power_level);
        check_field("filtered_mv", want.filtered_mv, level_ch.filtered_mv);
        check_field("settled", want.settled, level_ch.settled);
      end
    end
  end

  // Output side: random ready bursts, quiet stretches, none in the tail.
  initial begin
    int unsigned idle_left;
    int unsigned tick;
    bit          quiet;
    level_ch.ready = 1'b0;
    idle_left = 0;
    tick      = 0;
    quiet     = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 128 == 0)
        quiet = ($urandom_range(0, 3) == 0);
      if (stall_req) begin
        level_ch.ready <= 1'b0;
      end else if (idle_left != 0) begin
        idle_left--;
        level_ch.ready <= 1'b0;
      end else if (!tail_part && !quiet && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(0, 14);
        level_ch.ready <= 1'b0;
      end else begin
        level_ch.ready <= 1'b1;
      end
    end
  end

  // Hold off the output for a long stretch so the core backs up into its input.
  initial begin
    wait (rand_sent >= LONG_STALL_AT);
    @(posedge clk);
    stall_req = 1'b1;
    repeat (LONG_STALL) @(posedge clk);
    stall_req = 1'b0;
  end

  initial begin
    int unsigned       k;
    int unsigned       p;
    int unsigned       per_phase;
    logic [ADC_W-1:0]  last_adc;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    sample_ch.valid      = 1'b0;
    sample_ch.adc_sample = '0;
    reg_cfg   = '{SCALE_RST, ALPHA_FAST_RST, ALPHA_SLOW_RST, LOWEST_RST, RETURN_RST, WARN_RST};
    fv_q16    = FV_RST;
    settled_q = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        source_gap();
        send_sample(dir_rows[i].value[ADC_W-1:0], dir_rows[i].typed, dir_rows[i].want);
      end
    end

    per_phase = RAND_ITEMS / NUM_PHASES;
    last_adc  = '0;
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      configure_phase(p);
      for (k = 0; k < per_phase; k++) begin
        if (rand_sent == PAUSE_AT)
          wait_drained();
        source_gap();
        last_adc = pick_adc(last_adc);
        send_sample(last_adc, 1'b0, NO_LEVEL);
        rand_sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d samples (%0d directed), checked %0d level items, %0d register writes",
             samples_sent, samples_sent - rand_sent, results_seen, reg_writes);
    $display("Filter ended %s at %0d mV; %0d field mismatches",
             settled_q ? "settled" : "unsettled", fv_q16[FV_W-1:FRAC_W], mismatches);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
hdl/bvm_pkg.sv
hdl/bvm_if.sv
hdl/bvm_regs.sv
hdl/bvm_core.sv
hdl/battery_voltage_monitor.sv
hdl/bvm_checker.sv
verif/battery_voltage_monitor_test.sv
